// ===== hw/rtl/tgos_pkg.sv =====
`timescale 1ns / 1ps

package tgos_pkg;

    // tile geometry
    localparam int TILE_SHIFT   = 3;
    localparam int TILE_HALF_PX = 4;

    // datapath widths
    localparam int CFG_W       = 9;   // tiles_wide / tiles_high
    localparam int SPAN_W      = 3;   // span counts and span indexes
    localparam int COORD_W     = 14;  // tile coordinate plus span offset
    localparam int LT_W        = 11;  // layer * tiles_high
    localparam int ROW_W       = 14;  // layer * tiles_high + y
    localparam int SCAN_ADDR_W = 24;  // linear tile address before range check
    localparam int LAYER_CMP_W = 5;   // wide enough for the largest layer count

    localparam int QUEUE_DEPTH = 2;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register map, selected by paddr[2]
    localparam logic REG_TILES_WIDE = 1'b0;
    localparam logic REG_TILES_HIGH = 1'b1;

    localparam logic [CFG_W-1:0] TILES_RESET = 9'd64;

    typedef struct packed {
        logic        cmd;
        logic [15:0] tile_addr;
        logic [7:0]  tile_value;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic [1:0]  layer;
        logic [15:0] entity_id;
    } tgos_in_t;

    typedef struct packed {
        logic [15:0] hit_entity;
        logic [7:0]  tile_type;
        logic        last;
    } tgos_out_t;

    // one classified command waiting for the scan engine
    typedef struct packed {
        logic                   cmd;
        logic [15:0]            tile_addr;
        logic [7:0]             tile_value;
        logic [15:0]            entity_id;
        logic [COORD_W-1:0]     x0;
        logic [COORD_W-1:0]     y0;
        logic [SPAN_W-1:0]      xn;
        logic [SPAN_W-1:0]      yn;
        logic [SCAN_ADDR_W-1:0] base;   // (layer * tiles_high + y0) * tiles_wide
    } tgos_entry_t;

    // tiles covered along one axis, clamped
    function automatic logic [SPAN_W-1:0] span_count(
        input logic [15:0]       size,
        input logic [SPAN_W-1:0] max_span
    );
        logic [16:0] sum;
        logic [13:0] n;
        sum = {1'b0, size} + 17'(TILE_HALF_PX);
        n   = sum[16:TILE_SHIFT];
        if (n > {11'b0, max_span})
        begin
            return max_span;
        end
        return n[SPAN_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tgos_ram.sv =====
`timescale 1ns / 1ps

module tgos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tgos_queue.sv =====
`timescale 1ns / 1ps

module tgos_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tgos_pkg::tgos_entry_t din,
    output logic                  full,
    input  logic                  pop,
    output tgos_pkg::tgos_entry_t dout,
    output logic                  empty
);

    import tgos_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tgos_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/tgos_front.sv =====
`timescale 1ns / 1ps

module tgos_front #(
    parameter int LAYERS   = 4,
    parameter int MAX_SPAN = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  tgos_pkg::tgos_in_t           request,
    output logic                         ready,
    input  logic [tgos_pkg::CFG_W-1:0]   tiles_wide,
    input  logic [tgos_pkg::CFG_W-1:0]   tiles_high,
    output logic                         push,
    output tgos_pkg::tgos_entry_t        entry,
    input  logic                         full
);

    import tgos_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL1 = 2'd1;
    localparam logic [1:0] F_MUL2 = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam logic [SPAN_W-1:0]      SPAN_MAX    = SPAN_W'(MAX_SPAN);
    localparam logic [LAYER_CMP_W-1:0] LAYER_LIMIT = LAYER_CMP_W'(LAYERS);

    logic [1:0]              state_reg, state_next;
    tgos_entry_t             entry_reg, entry_next;
    logic [1:0]              layer_reg, layer_next;
    logic [LT_W-1:0]         lt_reg, lt_next;
    logic                    layer_ok;
    logic [ROW_W-1:0]        row_sum;
    logic [ROW_W+CFG_W-1:0]  row_prod;

    assign layer_ok = {{(LAYER_CMP_W-2){1'b0}}, request.layer} < LAYER_LIMIT;
    assign row_sum  = ROW_W'(lt_reg) + entry_reg.y0;
    assign row_prod = {{CFG_W{1'b0}}, row_sum} * {{ROW_W{1'b0}}, tiles_wide};

    assign ready = (state_reg == F_IDLE);
    assign push  = (state_reg == F_PUSH) && !full;
    assign entry = entry_reg;

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        layer_next = layer_reg;
        lt_next    = lt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    entry_next.cmd        = request.cmd;
                    entry_next.tile_addr  = request.tile_addr;
                    entry_next.tile_value = request.tile_value;
                    entry_next.entity_id  = request.entity_id;
                    entry_next.x0         = COORD_W'(request.rect_x >> TILE_SHIFT);
                    entry_next.y0         = COORD_W'(request.rect_y >> TILE_SHIFT);
                    entry_next.xn         = span_count(request.rect_w, SPAN_MAX);
                    // a layer beyond the map scans nothing
                    entry_next.yn         = layer_ok ? span_count(request.rect_h, SPAN_MAX)
                                                     : '0;
                    entry_next.base       = '0;
                    layer_next            = request.layer;
                    state_next            = (request.cmd == CMD_QUERY) ? F_MUL1 : F_PUSH;
                end
            end
            F_MUL1:
            begin
                lt_next    = LT_W'(layer_reg) * LT_W'(tiles_high);
                state_next = F_MUL2;
            end
            F_MUL2:
            begin
                entry_next.base = SCAN_ADDR_W'(row_prod);
                state_next      = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        layer_reg <= layer_next;
        lt_reg    <= lt_next;
    end

endmodule

// ===== hw/rtl/tgos_back.sv =====
`timescale 1ns / 1ps

module tgos_back #(
    parameter int GRID_DEPTH = 65536
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tgos_pkg::tgos_entry_t        head,
    input  logic                         empty,
    output logic                         pop,
    input  logic [tgos_pkg::CFG_W-1:0]   tiles_wide,
    input  logic [tgos_pkg::CFG_W-1:0]   tiles_high,
    output logic                         clearing,
    output logic                         result_valid,
    output tgos_pkg::tgos_out_t          result
);

    import tgos_pkg::*;

    localparam int MEM_AW = $clog2(GRID_DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [SCAN_ADDR_W-1:0] DEPTH_LIMIT = SCAN_ADDR_W'(GRID_DEPTH);
    localparam logic [MEM_AW-1:0]      CLEAR_LAST  = MEM_AW'(GRID_DEPTH - 1);

    logic [2:0]             state_reg, state_next;
    logic [MEM_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [SPAN_W-1:0]      i_reg, i_next, j_reg, j_next;
    logic [SPAN_W-1:0]      xn_reg, xn_next, yn_reg, yn_next;
    logic [COORD_W-1:0]     x_reg, x_next, y_reg, y_next, x0_reg, x0_next;
    logic [SCAN_ADDR_W-1:0] row_reg, row_next, addr_reg, addr_next;
    logic [15:0]            entity_reg, entity_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   res_valid_reg, res_valid_next;
    tgos_out_t              res_reg, res_next;

    logic                   ram_we;
    logic [MEM_AW-1:0]      ram_addr;
    logic [7:0]             ram_wdata, ram_rdata;
    logic [SCAN_ADDR_W-1:0] wr_addr_wide, start_addr, next_row;
    logic                   tile_ok;

    tgos_ram #(
        .WIDTH (8),
        .DEPTH (GRID_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign wr_addr_wide = SCAN_ADDR_W'(head.tile_addr);
    assign start_addr   = head.base + SCAN_ADDR_W'(head.x0);
    assign next_row     = row_reg + SCAN_ADDR_W'(tiles_wide);
    // tile inside the world and inside the memory
    assign tile_ok      = (y_reg < COORD_W'(tiles_high)) && (x_reg < COORD_W'(tiles_wide))
                          && (addr_reg < DEPTH_LIMIT);

    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        xn_next      = xn_reg;
        yn_next      = yn_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        x0_next      = x0_reg;
        row_next     = row_reg;
        addr_next    = addr_reg;
        entity_next  = entity_reg;
        rd_pend_next = 1'b0;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = addr_reg[MEM_AW-1:0];
        ram_wdata    = head.tile_value;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.cmd == CMD_QUERY)
                    begin
                        i_next      = '0;
                        j_next      = '0;
                        xn_next     = head.xn;
                        yn_next     = head.yn;
                        x_next      = head.x0;
                        x0_next     = head.x0;
                        y_next      = head.y0;
                        row_next    = start_addr;
                        addr_next   = start_addr;
                        entity_next = head.entity_id;
                        state_next  = (head.xn == '0 || head.yn == '0) ? ST_FINISH : ST_SCAN;
                    end
                    else
                    begin
                        // writes past the memory are dropped
                        ram_addr = wr_addr_wide[MEM_AW-1:0];
                        ram_we   = (wr_addr_wide < DEPTH_LIMIT);
                    end
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = tile_ok;
                if (i_reg == xn_reg - 1'b1)
                begin
                    if (j_reg == yn_reg - 1'b1)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next    = '0;
                        j_next    = j_reg + 1'b1;
                        x_next    = x0_reg;
                        y_next    = y_reg + 1'b1;
                        row_next  = next_row;
                        addr_next = next_row;
                    end
                end
                else
                begin
                    i_next    = i_reg + 1'b1;
                    x_next    = x_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // last read of the span lands this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hits pass the memory read register and then the result register, the end marker comes after the last hit
    always_comb
    begin
        res_valid_next      = (rd_pend_reg && ram_rdata != '0) || (state_reg == ST_FINISH);
        res_next.hit_entity = entity_reg;
        res_next.tile_type  = (state_reg == ST_FINISH) ? '0 : ram_rdata;
        res_next.last       = (state_reg == ST_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        xn_reg     <= xn_next;
        yn_reg     <= yn_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        x0_reg     <= x0_next;
        row_reg    <= row_next;
        addr_reg   <= addr_next;
        entity_reg <= entity_next;
        res_reg    <= res_next;
    end

endmodule

// ===== hw/rtl/tile_grid_overlap_scan.sv =====
`timescale 1ns / 1ps

// tile map overlap scanner. a command is taken at a clock edge with start high and busy
// low. a write command stores one tile byte (zero = empty) and gives no result. a query
// command turns a pixel rectangle into a span of up to MAX_SPAN x MAX_SPAN 8-pixel tiles
// on one layer, scans it row by row, and gives one result per nonzero tile followed by an
// end item with last set and tile_type zero. results are shown for exactly one cycle with
// result_valid high and cannot be held off, so the receiver must take every one. the front
// end classifies a command and computes the layer/row base address (a query passes
// F_MUL1 and F_MUL2, a write neither, before F_PUSH, which holds while the queue is
// full), then hands it through a two-entry queue to the scan engine. the scan engine owns
// a single-port tile memory and reads one tile per cycle; a query scans its span, then
// passes ST_DRAIN and ST_FINISH for the end item, an empty span or a layer past
// LAYERS goes straight to ST_FINISH, and a write ends in the idle state. busy
// stays high while the front end holds a command. after reset the engine zeroes the tile
// memory one entry per cycle, all GRID_DEPTH entries, with busy high; configuration
// writes are taken during that pass. tiles_wide and tiles_high sit at byte addresses 0
// and 4 of the register port and should only change while no query is in flight.
module tile_grid_overlap_scan #(
    parameter int GRID_DEPTH = 65536,
    parameter int LAYERS     = 4,
    parameter int MAX_SPAN   = 7
) (
    input  logic                clk,
    input  logic                rst_n,

    // command channel
    input  logic                start,
    output logic                busy,
    input  tgos_pkg::tgos_in_t  request,

    // result channel
    output logic                result_valid,
    output tgos_pkg::tgos_out_t result,

    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import tgos_pkg::*;

    logic [CFG_W-1:0] tiles_wide_reg, tiles_wide_next;
    logic [CFG_W-1:0] tiles_high_reg, tiles_high_next;
    logic             cfg_write;
    logic             accept;
    logic             front_ready;
    logic             clearing;
    logic             q_push, q_full, q_pop, q_empty;
    tgos_entry_t      q_din, q_dout;

    // a command transfer happens when start meets a free front end
    assign busy   = clearing || !front_ready;
    assign accept = start && !busy;

    // register port: zero wait states, one register per 32-bit word
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        tiles_wide_next = tiles_wide_reg;
        tiles_high_next = tiles_high_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TILES_WIDE: tiles_wide_next = pwdata[CFG_W-1:0];
                REG_TILES_HIGH: tiles_high_next = pwdata[CFG_W-1:0];
                default:        tiles_wide_next = tiles_wide_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TILES_WIDE: prdata = {{(32-CFG_W){1'b0}}, tiles_wide_reg};
            REG_TILES_HIGH: prdata = {{(32-CFG_W){1'b0}}, tiles_high_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_wide_reg <= TILES_RESET;
            tiles_high_reg <= TILES_RESET;
        end
        else
        begin
            tiles_wide_reg <= tiles_wide_next;
            tiles_high_reg <= tiles_high_next;
        end
    end

    // front end: latches the command, clamps the span, builds the row base address
    tgos_front #(
        .LAYERS   (LAYERS),
        .MAX_SPAN (MAX_SPAN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .request    (request),
        .ready      (front_ready),
        .tiles_wide (tiles_wide_reg),
        .tiles_high (tiles_high_reg),
        .push       (q_push),
        .entry      (q_din),
        .full       (q_full)
    );

    // decouples command intake from the scan engine
    tgos_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // scan engine: memory clear, tile writes, span scan and result register
    tgos_back #(
        .GRID_DEPTH (GRID_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_dout),
        .empty        (q_empty),
        .pop          (q_pop),
        .tiles_wide   (tiles_wide_reg),
        .tiles_high   (tiles_high_reg),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== hw/rtl/tgos_checker.sv =====
`timescale 1ns / 1ps

module tgos_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input tgos_pkg::tgos_out_t result
);

    import tgos_pkg::*;

    // memory clear keeps the block busy as reset lifts
    assert property (@(posedge clk) $rose(rst_n) |-> busy)
        else $error("busy low as reset lifts");

    // a command transfer always occupies the front end for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy low right after a command transfer");

    // end items carry no tile
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (result.tile_type == '0))
        else $error("end item with nonzero tile type");

    // hit items only for nonempty tiles
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (result.tile_type != '0))
        else $error("hit item with empty tile");

endmodule

bind tile_grid_overlap_scan tgos_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
